// ===== rtl/multi_queue_round_robin_arbiter_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the round robin arbiter
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MULTI_QUEUE_ROUND_ROBIN_ARBITER_TOP_MACROS_SVH
`define MULTI_QUEUE_ROUND_ROBIN_ARBITER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MQA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MQA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mqa_pkg.sv =====
// ---------------------------------------------------------------------------
// mqa_pkg
// Shared constants and types of the multi queue round robin arbiter.
// ---------------------------------------------------------------------------
`default_nettype none

package mqa_pkg;

  localparam int MQA_MAX_PRODUCERS = 8;
  localparam int MQA_QUEUE_DEPTH   = 16;
  localparam int MQA_DATA_WIDTH    = 64;

  localparam int SRC_W   = 3;
  localparam int ENTRY_W = 64;
  localparam int ACT_W   = 4;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [CFG_AW-3:0] REG_ACTIVE_PRODUCERS = '0;
  localparam logic [ACT_W-1:0]  ACTIVE_RESET         = 4'd8;

  typedef enum logic [1:0] {
    PUSH_OK        = 2'd0,
    PUSH_FULL      = 2'd1,
    PUSH_BAD_INDEX = 2'd2,
    PUSH_NONE      = 2'd3
  } push_status_t;

  // Decision made by the front end for one request
  typedef struct packed {
    push_status_t       status;
    logic               pop_valid;
    logic [SRC_W-1:0]   src;
  } mqa_op_t;

endpackage

`default_nettype wire

// ===== rtl/mqa_in_if.sv =====
// ---------------------------------------------------------------------------
// mqa_in_if
// Request channel: push or pop command with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface mqa_in_if
  import mqa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [SRC_W-1:0]   producer_index;
  logic [ENTRY_W-1:0] entry_data;

  modport source (output valid, output cmd, output producer_index, output entry_data,
                  input ready);
  modport sink   (input valid, input cmd, input producer_index, input entry_data,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/mqa_out_if.sv =====
// ---------------------------------------------------------------------------
// mqa_out_if
// Result channel: push status and popped word with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface mqa_out_if
  import mqa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         push_status;
  logic               pop_valid;
  logic [SRC_W-1:0]   pop_source;
  logic [ENTRY_W-1:0] pop_data;

  modport source (output valid, output push_status, output pop_valid, output pop_source,
                  output pop_data, input ready);
  modport sink   (input valid, input push_status, input pop_valid, input pop_source,
                  input pop_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/multi_queue_round_robin_arbiter_top.sv =====
// ---------------------------------------------------------------------------
// multi_queue_round_robin_arbiter_top: per-producer FIFOs, round robin pop
// An accepted request passes op queue, storage access and output register to a
// valid result; one request per cycle sustained while out_if.ready stays high
// and no pointer reload is pending. After reset and each change of the effective
// count, ready is low while the round robin pointer is reloaded and folded into range.
// Sync reset empties all queues, clears the pointer, sets the count to 8.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_queue_round_robin_arbiter_top
  import mqa_pkg::*;
#(
  parameter int MAX_PRODUCERS = MQA_MAX_PRODUCERS,
  parameter int QUEUE_DEPTH   = MQA_QUEUE_DEPTH,
  parameter int DATA_WIDTH    = MQA_DATA_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  mqa_in_if.sink            in_if,
  mqa_out_if.source         out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int MAW = $clog2(MAX_PRODUCERS * QUEUE_DEPTH);

  logic [ACT_W-1:0] active_r;
  logic             cfg_wr, cfg_hit;

  logic                  f_valid, f_ready, b_valid, b_ready;
  mqa_op_t               f_op, b_op;
  logic [MAW-1:0]        f_addr, b_addr;
  logic [DATA_WIDTH-1:0] f_data, b_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_hit    = cfg_paddr[CFG_AW-1:2] == REG_ACTIVE_PRODUCERS;
  assign cfg_prdata = cfg_hit ? CFG_DW'(active_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr && cfg_hit) begin
      active_r <= cfg_pwdata[ACT_W-1:0];
    end
  end

  mqa_front #(
    .MAX_PRODUCERS (MAX_PRODUCERS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .active_cnt (active_r),
    .op_valid   (f_valid),
    .op_ready   (f_ready),
    .op         (f_op),
    .op_addr    (f_addr),
    .op_data    (f_data)
  );

  mqa_op_fifo #(
    .AW (MAW),
    .DW (DATA_WIDTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (f_valid),
    .enq_ready (f_ready),
    .enq_op    (f_op),
    .enq_addr  (f_addr),
    .enq_data  (f_data),
    .deq_valid (b_valid),
    .deq_ready (b_ready),
    .deq_op    (b_op),
    .deq_addr  (b_addr),
    .deq_data  (b_data)
  );

  mqa_back #(
    .MAX_PRODUCERS (MAX_PRODUCERS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (b_valid),
    .op_ready (b_ready),
    .op       (b_op),
    .op_addr  (b_addr),
    .op_data  (b_data),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire

// ===== rtl/mqa_front.sv =====
// ---------------------------------------------------------------------------
// mqa_front
// Accepts requests, keeps per-queue head/tail/fill and the round robin
// pointer, and turns each request into one storage operation.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_queue_round_robin_arbiter_top_macros.svh"

module mqa_front
  import mqa_pkg::*;
#(
  parameter int MAX_PRODUCERS = MQA_MAX_PRODUCERS,
  parameter int QUEUE_DEPTH   = MQA_QUEUE_DEPTH,
  parameter int DATA_WIDTH    = MQA_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mqa_in_if.sink                in_if,
  input  logic [ACT_W-1:0]      active_cnt,
  output logic                  op_valid,
  input  logic                  op_ready,
  output mqa_op_t               op,
  output logic [$clog2(MAX_PRODUCERS*QUEUE_DEPTH)-1:0] op_addr,
  output logic [DATA_WIDTH-1:0] op_data
);

  localparam int QW  = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;
  localparam int IW  = (QW > SRC_W) ? QW : SRC_W;
  localparam int CW  = (QW + 1 > ACT_W) ? QW + 1 : ACT_W;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int MAW = $clog2(MAX_PRODUCERS * QUEUE_DEPTH);

  logic [PW-1:0] head_r [MAX_PRODUCERS];
  logic [PW-1:0] tail_r [MAX_PRODUCERS];
  logic [FW-1:0] fill_r [MAX_PRODUCERS];

  logic [CW-1:0]            ns_r, ns_nxt, n_eff, start_r, start_nxt, seen_r, rr_wrap;
  logic [MAX_PRODUCERS-1:0] active, nonempty, full, hi, lo;
  logic [QW-1:0]            q_idx, pick, pick_hi, pick_lo;
  logic [IW-1:0]            q_ext, pick_ext;
  logic                     any_hi, pop_hit, in_range, norm_busy, in_acc, is_push, push_ok;
  logic                     resync, pop_adv;
  push_status_t             status;

  function automatic logic [MAW-1:0] slot_addr(logic [QW-1:0] q, logic [PW-1:0] s);
    return MAW'(q) * MAW'(QUEUE_DEPTH) + MAW'(s);
  endfunction

  function automatic logic [PW-1:0] slot_inc(logic [PW-1:0] s);
    return (s == PW'(QUEUE_DEPTH - 1)) ? '0 : s + PW'(1);
  endfunction

  // Zero acts as one, anything above the queue count saturates
  always_comb begin
    if (active_cnt == '0) begin
      n_eff = CW'(1);
    end else if (CW'(active_cnt) > CW'(MAX_PRODUCERS)) begin
      n_eff = CW'(MAX_PRODUCERS);
    end else begin
      n_eff = CW'(active_cnt);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PRODUCERS; i++) begin
      active[i]   = CW'(i) < n_eff;
      nonempty[i] = fill_r[i] != '0;
      full[i]     = fill_r[i] == FW'(QUEUE_DEPTH);
      hi[i]       = active[i] && nonempty[i] && (CW'(i) >= start_r);
      lo[i]       = active[i] && nonempty[i] && (CW'(i) < start_r);
    end
  end

  // Rotated priority: first ready queue at or after the pointer, else wrap
  always_comb begin
    pick_hi = '0;
    pick_lo = '0;
    for (int i = MAX_PRODUCERS - 1; i >= 0; i--) begin
      if (hi[i]) pick_hi = QW'(i);
      if (lo[i]) pick_lo = QW'(i);
    end
  end

  assign any_hi   = |hi;
  assign pop_hit  = |(hi | lo);
  assign pick     = any_hi ? pick_hi : pick_lo;
  assign pick_ext = IW'(pick);

  assign q_ext    = IW'(in_if.producer_index);
  assign q_idx    = q_ext[QW-1:0];
  assign in_range = CW'(in_if.producer_index) < n_eff;
  assign is_push  = in_if.cmd == CMD_PUSH;
  assign push_ok  = is_push && in_range && !full[q_idx];

  always_comb begin
    if (!is_push) begin
      status = PUSH_NONE;
    end else if (!in_range) begin
      status = PUSH_BAD_INDEX;
    end else if (full[q_idx]) begin
      status = PUSH_FULL;
    end else begin
      status = PUSH_OK;
    end
  end

  // ns_r keeps the pointer as stored; start_r is its working copy, reloaded
  // on every count change and folded back one subtraction per cycle before
  // more requests are taken, so a raised count sees the old pointer again.
  assign resync      = n_eff != seen_r;
  assign norm_busy   = resync || (start_r >= n_eff);
  assign in_if.ready = op_ready && !norm_busy;
  assign in_acc      = in_if.valid && in_if.ready;
  assign pop_adv     = in_acc && !is_push && pop_hit;
  assign rr_wrap     = (CW'(pick) + CW'(1) == n_eff) ? '0 : CW'(pick) + CW'(1);

  always_comb begin
    if (resync) begin
      start_nxt = ns_r;
    end else if (start_r >= n_eff) begin
      start_nxt = start_r - n_eff;
    end else if (pop_adv) begin
      start_nxt = rr_wrap;
    end else begin
      start_nxt = start_r;
    end
  end

  assign ns_nxt = pop_adv ? rr_wrap : ns_r;

  assign op_valid     = in_acc;
  assign op.status    = status;
  assign op.pop_valid = !is_push && pop_hit;
  assign op.src       = op.pop_valid ? pick_ext[SRC_W-1:0] : '0;
  assign op_addr      = is_push ? slot_addr(q_idx, tail_r[q_idx])
                                : slot_addr(pick, head_r[pick]);
  assign op_data      = in_if.entry_data[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r    <= '0;
      start_r <= '0;
      seen_r  <= '0;
      for (int i = 0; i < MAX_PRODUCERS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      ns_r    <= ns_nxt;
      start_r <= start_nxt;
      seen_r  <= n_eff;
      if (in_acc && push_ok) begin
        tail_r[q_idx] <= slot_inc(tail_r[q_idx]);
        fill_r[q_idx] <= fill_r[q_idx] + FW'(1);
      end
      if (in_acc && op.pop_valid) begin
        head_r[pick] <= slot_inc(head_r[pick]);
        fill_r[pick] <= fill_r[pick] - FW'(1);
      end
    end
  end

  `MQA_ASSERT_SAME(a_pick_ready, in_acc && op.pop_valid, nonempty[pick] && active[pick], "pop picked an empty or inactive queue")

endmodule

`default_nettype wire

// ===== rtl/mqa_op_fifo.sv =====
// ---------------------------------------------------------------------------
// mqa_op_fifo
// Two-entry queue of storage operations between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_queue_round_robin_arbiter_top_macros.svh"

module mqa_op_fifo
  import mqa_pkg::*;
#(
  parameter int AW = 7,
  parameter int DW = MQA_DATA_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enq_valid,
  output logic          enq_ready,
  input  mqa_op_t       enq_op,
  input  logic [AW-1:0] enq_addr,
  input  logic [DW-1:0] enq_data,
  output logic          deq_valid,
  input  logic          deq_ready,
  output mqa_op_t       deq_op,
  output logic [AW-1:0] deq_addr,
  output logic [DW-1:0] deq_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mqa_op_t       op_q   [DEPTH];
  logic [AW-1:0] addr_q [DEPTH];
  logic [DW-1:0] data_q [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             enq, deq;

  assign enq_ready = cnt_r != CNT_W'(DEPTH);
  assign deq_valid = cnt_r != '0;
  assign enq       = enq_valid && enq_ready;
  assign deq       = deq_valid && deq_ready;

  assign deq_op   = op_q[rd_ptr_r];
  assign deq_addr = addr_q[rd_ptr_r];
  assign deq_data = data_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (enq) begin
      op_q[wr_ptr_r]   <= enq_op;
      addr_q[wr_ptr_r] <= enq_addr;
      data_q[wr_ptr_r] <= enq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (deq) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (enq && !deq) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (deq && !enq) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  `MQA_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "op queue count out of range")

endmodule

`default_nettype wire

// ===== rtl/mqa_back.sv =====
// ---------------------------------------------------------------------------
// mqa_back
// Owns the word storage, performs each write or read, and holds the
// result in an output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_queue_round_robin_arbiter_top_macros.svh"

module mqa_back
  import mqa_pkg::*;
#(
  parameter int MAX_PRODUCERS = MQA_MAX_PRODUCERS,
  parameter int QUEUE_DEPTH   = MQA_QUEUE_DEPTH,
  parameter int DATA_WIDTH    = MQA_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  op_valid,
  output logic                  op_ready,
  input  mqa_op_t               op,
  input  logic [$clog2(MAX_PRODUCERS*QUEUE_DEPTH)-1:0] op_addr,
  input  logic [DATA_WIDTH-1:0] op_data,
  mqa_out_if.source             out_if
);

  localparam int MEM_DEPTH = MAX_PRODUCERS * QUEUE_DEPTH;

  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic    s1_vld_r;
  mqa_op_t s1_op_r;
  logic    s1_adv, ld;

  logic               out_vld_r;
  push_status_t       out_status_r;
  logic               out_pop_valid_r;
  logic [SRC_W-1:0]   out_pop_source_r;
  logic [ENTRY_W-1:0] out_pop_data_r;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_if.ready);
  assign op_ready = !s1_vld_r || s1_adv;
  assign ld       = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (ld && op.status == PUSH_OK) mem[op_addr] <= op_data;
    if (ld && op.pop_valid) rd_data_r <= mem[op_addr];
    if (ld) s1_op_r <= op;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r     <= s1_op_r.status;
      out_pop_valid_r  <= s1_op_r.pop_valid;
      out_pop_source_r <= s1_op_r.src;
      out_pop_data_r   <= s1_op_r.pop_valid ? ENTRY_W'(rd_data_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (ld) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.push_status = out_status_r;
  assign out_if.pop_valid   = out_pop_valid_r;
  assign out_if.pop_source  = out_pop_source_r;
  assign out_if.pop_data    = out_pop_data_r;

  `MQA_ASSERT_NEXT(a_s1_hold, s1_vld_r && !s1_adv, s1_vld_r && $stable(s1_op_r), "access stage lost a stalled request")
  `MQA_ASSERT_SAME(a_empty_pop, out_vld_r && !out_pop_valid_r, out_pop_data_r == '0 && out_pop_source_r == '0, "empty result carries data")

endmodule

`default_nettype wire
